>>> rtl/futp_pkg.sv
// Shared types and constants for the font unicode table parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package futp_pkg;

    // Byte classification constants of the UTF-8 style table encoding.
    localparam logic [7:0] GLYPH_END_BYTE = 8'hFF;
    localparam logic [7:0] ASCII_TOP_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK     = 8'hE0;
    localparam logic [7:0] LEAD2_CODE     = 8'hC0;
    localparam logic [7:0] LEAD2_PAYLOAD  = 8'h1F;
    localparam logic [7:0] CONT_PAYLOAD   = 8'h3F;
    localparam logic [7:0] LEAD3_MASK     = 8'hF0;
    localparam logic [7:0] LEAD3_CODE     = 8'hE0;
    localparam logic [7:0] LEAD3_PAYLOAD  = 8'h0F;
    localparam logic [7:0] LEAD4_MASK     = 8'hF8;
    localparam logic [7:0] LEAD4_CODE     = 8'hF0;

    localparam int unsigned POINT_W = 16;
    localparam int unsigned GLYPH_W = 16;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_TWO   = 2'd1,
        KIND_THREE = 2'd2,
        KIND_FOUR  = 2'd3
    } seq_kind_t;

    // Sequence state carried from one byte to the next.
    typedef struct packed {
        logic [GLYPH_W-1:0] glyph_counter;
        logic [1:0]         bytes_pending;
        seq_kind_t          sequence_kind;
        logic [POINT_W-1:0] point_accumulator;
    } parse_state_t;

    // One map write: code point and the glyph it maps to.
    typedef struct packed {
        logic [POINT_W-1:0] code_point;
        logic [GLYPH_W-1:0] glyph_number;
    } map_word_t;

endpackage

`default_nettype wire

>>> rtl/font_unicode_table_parser.sv
// Top level of the font unicode table parser.
// Depends on futp_pkg, futp_decode and futp_out_buf.
`default_nettype none

// The parser takes the unicode mapping table of a bitmap font one byte per
// word on the s_ channel and emits one map word (code point, glyph number)
// on the m_ channel for every character it decodes. A byte 0xFF closes the
// entries of the current glyph and advances the glyph number, which wraps
// from 0xFFFF to 0. Bytes below 0x80 map directly; two- and three-byte
// UTF-8 leads take the next one or two bytes as continuations whatever
// their value, and four-byte leads take three bytes and map code point 0.
// Other bytes with the top bit set are dropped silently. The decode is a
// single pass of logic from the sequence state registers to the output
// register, so a byte can be accepted on every clock while s_ready is
// high. A one-word skid stage behind the output register lets the parser
// keep accepting while one decoded word waits; s_ready drops only when both
// the output register and the skid stage hold words. A sequence cut short
// simply waits for its next byte. After reset the glyph number is 0.

module font_unicode_table_parser
    import futp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_table_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [POINT_W-1:0]      m_code_point,
    output logic [GLYPH_W-1:0]      m_glyph_number
);

    parse_state_t state_reg, state_next;
    parse_state_t dec_state;
    logic         dec_valid;
    map_word_t    dec_word;
    map_word_t    out_word;
    logic         buf_room;
    logic         in_fire;

    assign s_ready = buf_room;
    assign in_fire = s_valid && buf_room;

    // Sequence decode of the incoming byte against the registered state.
    futp_decode u_decode (
        .table_byte (s_table_byte),
        .state_cur  (state_reg),
        .state_next (dec_state),
        .word_valid (dec_valid),
        .word       (dec_word)
    );

    // The state advances only when a byte is actually accepted.
    assign state_next = in_fire ? dec_state : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.glyph_counter     <= '0;
            state_reg.bytes_pending     <= 2'd0;
            state_reg.sequence_kind     <= KIND_NONE;
            state_reg.point_accumulator <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    // Output register plus skid stage toward the map writer.
    futp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_fire && dec_valid),
        .in_room   (buf_room),
        .in_word   (dec_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign m_code_point   = out_word.code_point;
    assign m_glyph_number = out_word.glyph_number;

endmodule

`default_nettype wire

>>> rtl/futp_decode.sv
// Combinational byte decoder: next sequence state and optional map word.
// Depends on futp_pkg.
`default_nettype none

module futp_decode
    import futp_pkg::*;
(
    input  wire logic [7:0]   table_byte,
    input  wire parse_state_t state_cur,
    output parse_state_t      state_next,
    output logic              word_valid,
    output map_word_t         word
);

    logic [5:0]         low6;
    logic [POINT_W-1:0] acc_next;
    logic [1:0]         pending_dec;

    assign low6        = table_byte[5:0] & CONT_PAYLOAD[5:0];
    assign pending_dec = state_cur.bytes_pending - 2'd1;

    always_comb begin
        acc_next = state_cur.point_accumulator;
        unique case (state_cur.sequence_kind)
            KIND_TWO: begin
                acc_next = state_cur.point_accumulator | {10'd0, low6};
            end
            KIND_THREE: begin
                if (state_cur.bytes_pending == 2'd2) begin
                    acc_next = state_cur.point_accumulator | {4'd0, low6, 6'd0};
                end else begin
                    acc_next = state_cur.point_accumulator | {10'd0, low6};
                end
            end
            default: begin
                acc_next = state_cur.point_accumulator;
            end
        endcase
    end

    always_comb begin
        state_next        = state_cur;
        word_valid        = 1'b0;
        word.code_point   = '0;
        word.glyph_number = state_cur.glyph_counter;

        if (state_cur.bytes_pending != 2'd0) begin
            // Every byte is taken as a continuation byte while one is due.
            state_next.point_accumulator = acc_next;
            state_next.bytes_pending     = pending_dec;
            if (pending_dec == 2'd0) begin
                word_valid               = 1'b1;
                word.code_point          = (state_cur.sequence_kind == KIND_FOUR) ?
                                           '0 : acc_next;
                state_next.sequence_kind = KIND_NONE;
            end
        end else if (table_byte == GLYPH_END_BYTE) begin
            state_next.glyph_counter = state_cur.glyph_counter + 16'd1;
        end else if ((table_byte & ASCII_TOP_MASK) == 8'h00) begin
            word_valid      = 1'b1;
            word.code_point = {8'd0, table_byte};
        end else if ((table_byte & LEAD2_MASK) == LEAD2_CODE) begin
            state_next.point_accumulator = {5'd0, table_byte[4:0] & LEAD2_PAYLOAD[4:0], 6'd0};
            state_next.bytes_pending     = 2'd1;
            state_next.sequence_kind     = KIND_TWO;
        end else if ((table_byte & LEAD3_MASK) == LEAD3_CODE) begin
            state_next.point_accumulator = {table_byte[3:0] & LEAD3_PAYLOAD[3:0], 12'd0};
            state_next.bytes_pending     = 2'd2;
            state_next.sequence_kind     = KIND_THREE;
        end else if ((table_byte & LEAD4_MASK) == LEAD4_CODE) begin
            state_next.point_accumulator = '0;
            state_next.bytes_pending     = 2'd3;
            state_next.sequence_kind     = KIND_FOUR;
        end
    end

endmodule

`default_nettype wire

>>> rtl/futp_out_buf.sv
// Output register with a one-word skid stage for the map word channel.
// Depends on futp_pkg.
`default_nettype none

module futp_out_buf
    import futp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_room,
    input  wire map_word_t in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output map_word_t      out_word
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    map_word_t out_word_reg, out_word_next;
    map_word_t skid_word_reg, skid_word_next;
    logic      out_fire;

    assign out_fire  = out_valid_reg && out_ready;
    assign in_room   = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg) begin
            // The skid word moves up once the output word is taken.
            if (out_fire) begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || out_fire) begin
                out_word_next  = in_word;
                out_valid_next = 1'b1;
            end else begin
                skid_word_next  = in_word;
                skid_valid_next = 1'b1;
            end
        end else if (out_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule

`default_nettype wire
